/* hw/rtl/nearest_centroid_assign_top_assert.svh */
// Assertion macros for the nearest-centroid block.
// Included by the top level; bodies are empty when SYNTHESIS is defined.
`ifndef NEAREST_CENTROID_ASSIGN_TOP_ASSERT_SVH
`define NEAREST_CENTROID_ASSIGN_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define NCA_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("nca assertion failed");
`define NCA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("nca assertion failed");
`else
`define NCA_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define NCA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* hw/rtl/nca_pkg.sv */
// Shared constants, types and codes for the nearest-centroid block.
// No dependencies; used by the interfaces, the cell row and the top level.
package nca_pkg;

    localparam int MAX_CENTROIDS = 16;
    localparam int DIMENSIONS    = 5;
    localparam int VALUE_BITS    = 16;

    localparam int ACC_W       = 40;
    localparam int LABEL_W     = 8;
    localparam int RES_W       = 9;
    localparam int ACTION_W    = 2;
    localparam int ENTRY_W     = 4;
    localparam int DIM_W       = 3;
    localparam int CFG_CNT_W   = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 40;

    localparam int CENT_IDX_W  = $clog2(MAX_CENTROIDS);
    localparam int DIM_IDX_W   = $clog2(DIMENSIONS);
    localparam int ACT_CNT_W   = $clog2(MAX_CENTROIDS + 1);
    localparam int DIFF_W      = VALUE_BITS + 1;
    localparam int SQ_W        = 2 * DIFF_W;
    localparam int SEQ_CNT_W   = $clog2(MAX_CENTROIDS + 4);

    localparam logic [ACC_W-1:0] ACC_MAX    = {ACC_W{1'b1}};
    localparam logic [RES_W-1:0] LABEL_NONE = {RES_W{1'b1}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_COORD = 2'd0,
        ACT_SET_LABEL  = 2'd1,
        ACT_POINT      = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTROIDS_IN_USE = 1'b0,
        CFG_REJECT_SQ_DIST   = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DELIVER
    } t_state;

    // token walking the cell row: a point coordinate or a best-match sweep
    typedef struct packed {
        logic                          valid;
        logic                          cmp;
        logic [DIM_W-1:0]              dim;
        logic signed [VALUE_BITS-1:0]  value;
        logic [ACC_W-1:0]              best;
        logic [RES_W-1:0]              res;
    } t_tok;

    // broadcast store write
    typedef struct packed {
        logic                          coord_we;
        logic                          label_we;
        logic [ENTRY_W-1:0]            entry;
        logic [DIM_W-1:0]              dim;
        logic signed [VALUE_BITS-1:0]  value;
        logic [LABEL_W-1:0]            label;
    } t_load;

endpackage

/* hw/rtl/nca_in_if.sv */
// Input channel of the nearest-centroid block: one item per beat.
// Depends on nca_pkg.
interface nca_in_if import nca_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic [ACTION_W-1:0]           action;
    logic [ENTRY_W-1:0]            entry;
    logic [DIM_W-1:0]              dim;
    logic signed [VALUE_BITS-1:0]  value;
    logic [LABEL_W-1:0]            cluster_label;
    logic                          last;

    modport source (output valid, action, entry, dim, value, cluster_label, last,
                    input ready);
    modport sink   (input valid, action, entry, dim, value, cluster_label, last,
                    output ready);
endinterface

/* hw/rtl/nca_out_if.sv */
// Result channel of the nearest-centroid block: one label per beat.
// Depends on nca_pkg.
interface nca_out_if import nca_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [RES_W-1:0]  label;

    modport source (output valid, label, input ready);
    modport sink   (input valid, label, output ready);
endinterface

/* hw/rtl/nca_cell.sv */
// One centroid cell: coordinates, label and distance accumulator.
// Squares the token's coordinate difference, then compares on a sweep token.
// Depends on nca_pkg.
module nca_cell import nca_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [CENT_IDX_W-1:0] i_idx,
    input  logic [ACT_CNT_W-1:0]  i_active,
    input  t_load                 i_load,
    input  t_tok                  i_tok,
    output t_tok                  o_tok
);

    logic signed [VALUE_BITS-1:0] r_coord [DIMENSIONS];
    logic [LABEL_W-1:0]           r_label;
    logic [ACC_W-1:0]             r_acc, n_acc;
    logic [SQ_W-1:0]              r_sq, n_sq;
    logic                         r_sq_v, n_sq_v;
    t_tok                         r_tok, n_tok;

    logic                         in_use;
    logic                         dim_ok;
    logic signed [VALUE_BITS-1:0] coord;
    logic [DIFF_W-1:0]            diff;
    logic [DIFF_W-1:0]            mag;
    logic [ACC_W:0]               sum;

    always_comb begin
        in_use = ACT_CNT_W'(i_idx) < i_active;
        dim_ok = i_tok.dim < DIM_W'(DIMENSIONS);
        coord  = r_coord[i_tok.dim[DIM_IDX_W-1:0]];
        diff   = {i_tok.value[VALUE_BITS-1], i_tok.value}
               - {coord[VALUE_BITS-1], coord};
        mag    = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
        n_sq   = mag * mag;
        n_sq_v = i_tok.valid && !i_tok.cmp && in_use && dim_ok;
    end

    always_comb begin
        sum   = {1'b0, r_acc} + (ACC_W + 1)'(r_sq);
        n_acc = r_acc;
        if (r_sq_v) begin
            n_acc = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
        end
        if (i_tok.valid && i_tok.cmp) begin
            n_acc = '0;
        end
    end

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && i_tok.cmp && in_use && (r_acc < i_tok.best)) begin
            n_tok.best = r_acc;
            n_tok.res  = {1'b0, r_label};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
            r_sq_v      <= 1'b0;
            r_acc       <= '0;
        end else begin
            r_tok  <= n_tok;
            r_sq_v <= n_sq_v;
            r_acc  <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq <= n_sq;
        if (i_load.coord_we && (i_load.entry == ENTRY_W'(i_idx))
                && (i_load.dim < DIM_W'(DIMENSIONS))) begin
            r_coord[i_load.dim[DIM_IDX_W-1:0]] <= i_load.value;
        end
        if (i_load.label_we && (i_load.entry == ENTRY_W'(i_idx))) begin
            r_label <= i_load.label;
        end
    end

    assign o_tok = r_tok;

endmodule

/* hw/rtl/nca_chain.sv */
// Row of centroid cells; tokens move one cell per cycle.
// Depends on nca_pkg and nca_cell.
module nca_chain import nca_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [ACT_CNT_W-1:0]     i_active,
    input  t_load                    i_load,
    input  t_tok                     i_tok,
    output t_tok                     o_tok,
    output logic [MAX_CENTROIDS-1:0] o_busy
);

    t_tok link [MAX_CENTROIDS+1];

    assign link[0] = i_tok;

    for (genvar g = 0; g < MAX_CENTROIDS; g++) begin : g_cell
        nca_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_idx    (CENT_IDX_W'(g)),
            .i_active (i_active),
            .i_load   (i_load),
            .i_tok    (link[g]),
            .o_tok    (link[g+1])
        );
        assign o_busy[g] = link[g+1].valid;
    end

    assign o_tok = link[MAX_CENTROIDS];

endmodule

/* hw/rtl/nearest_centroid_assign_top.sv */
// Nearest-centroid classifier, top level: sequencer, registers, result beat.
// Depends on nca_pkg, nca_in_if, nca_out_if, nca_chain and the assertion macros.
//
// Use: i_item carries one beat per item. Action 0 writes a centroid coordinate,
// action 1 a centroid label; neither leaves the idle state. Action 2 streams one
// point coordinate, which walks the row of 16 centroid cells, one cell per cycle;
// the next item is taken only once the sequencer is back in idle. On the point's
// last coordinate a best-match sweep follows it down the row; when it leaves the
// row the label (-1 when no centroid beats the reject distance) is registered,
// then put on o_result once the output register is free.
// Configuration: i_cfg_we with i_cfg_idx 0 (centroids in use) or 1 (reject
// squared distance); the user writes it only while the block is idle, unchecked.
// Reset clears the registers to 0 centroids and the largest reject distance,
// zeroes the accumulators; stores hold junk until written.
// A stalled receiver holds the result in the output register; further items
// are taken meanwhile, and a next result waits until the register frees.
`include "nearest_centroid_assign_top_assert.svh"
module nearest_centroid_assign_top import nca_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    nca_in_if.sink                i_item,
    nca_out_if.source             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state                  r_state, n_state;
    logic [SEQ_CNT_W-1:0]    r_cnt, n_cnt;
    logic                    r_last_pend, n_last_pend;
    t_tok                    r_inj, n_inj;
    logic [RES_W-1:0]        r_res, n_res;
    logic                    r_out_v, n_out_v;
    logic [RES_W-1:0]        r_out_label, n_out_label;
    logic [CFG_CNT_W-1:0]    r_cent_in_use;
    logic [ACC_W-1:0]        r_reject;

    logic [ACT_CNT_W-1:0]    active;
    logic                    accept;
    logic                    is_point;
    logic                    launch_cmp;
    logic                    sweep_done;
    logic                    out_free;
    logic                    deliver;
    t_load                   load;
    t_tok                    chain_out;
    logic [MAX_CENTROIDS-1:0] chain_busy;

    assign active = (r_cent_in_use > CFG_CNT_W'(MAX_CENTROIDS))
                  ? ACT_CNT_W'(MAX_CENTROIDS) : ACT_CNT_W'(r_cent_in_use);

    assign accept     = i_item.valid && i_item.ready;
    assign is_point   = (t_action'(i_item.action) == ACT_POINT);
    assign sweep_done = chain_out.valid && chain_out.cmp;
    assign out_free   = !r_out_v || o_result.ready;

    always_comb begin
        load.coord_we = accept && (t_action'(i_item.action) == ACT_LOAD_COORD);
        load.label_we = accept && (t_action'(i_item.action) == ACT_SET_LABEL);
        load.entry    = i_item.entry;
        load.dim      = i_item.dim;
        load.value    = i_item.value;
        load.label    = i_item.cluster_label;
    end

    nca_chain u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_active (active),
        .i_load   (load),
        .i_tok    (r_inj),
        .o_tok    (chain_out),
        .o_busy   (chain_busy)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && is_point) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_last_pend) begin
                    if (sweep_done) begin
                        n_state = ST_DELIVER;
                    end
                end else if (r_cnt == SEQ_CNT_W'(MAX_CENTROIDS)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DELIVER: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_item.ready = 1'b0;
        launch_cmp   = 1'b0;
        deliver      = 1'b0;
        case (r_state)
            ST_IDLE:    i_item.ready = 1'b1;
            ST_RUN:     launch_cmp   = r_last_pend && (r_cnt == SEQ_CNT_W'(1));
            ST_DELIVER: deliver      = out_free;
            default: ;
        endcase
    end

    always_comb begin
        n_cnt       = (r_state == ST_RUN) ? r_cnt + SEQ_CNT_W'(1) : '0;
        n_last_pend = r_last_pend;
        if (accept && is_point) begin
            n_last_pend = i_item.last;
        end

        n_inj       = r_inj;
        n_inj.valid = 1'b0;
        if (accept && is_point) begin
            n_inj.valid = 1'b1;
            n_inj.cmp   = 1'b0;
            n_inj.dim   = i_item.dim;
            n_inj.value = i_item.value;
        end else if (launch_cmp) begin
            n_inj.valid = 1'b1;
            n_inj.cmp   = 1'b1;
            n_inj.best  = r_reject;
            n_inj.res   = LABEL_NONE;
        end

        n_res = sweep_done ? chain_out.res : r_res;

        n_out_v     = r_out_v && !o_result.ready;
        n_out_label = r_out_label;
        if (deliver) begin
            n_out_v     = 1'b1;
            n_out_label = r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_cnt         <= '0;
            r_last_pend   <= 1'b0;
            r_inj.valid   <= 1'b0;
            r_out_v       <= 1'b0;
            r_cent_in_use <= '0;
            r_reject      <= ACC_MAX;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_last_pend <= n_last_pend;
            r_inj       <= n_inj;
            r_out_v     <= n_out_v;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_CENTROIDS_IN_USE: r_cent_in_use <= i_cfg_data[CFG_CNT_W-1:0];
                    CFG_REJECT_SQ_DIST:   r_reject      <= i_cfg_data[ACC_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res       <= n_res;
        r_out_label <= n_out_label;
    end

    assign o_result.valid = r_out_v;
    assign o_result.label = r_out_label;

    `NCA_ASSERT_SAME(a_sweep_in_run, i_clk, i_rst_n, sweep_done,
        (r_state == ST_RUN) && r_last_pend)
    `NCA_ASSERT_SAME(a_row_occupancy, i_clk, i_rst_n, 1'b1,
        ($countones({chain_busy, r_inj.valid}) <= 2))
    `NCA_ASSERT_NEXT(a_deliver_loads, i_clk, i_rst_n, deliver,
        r_out_v && (r_state == ST_IDLE))

endmodule
